// File: sv/evr_pkg.sv
// Shared types, widths and constants of the Euler vertex rotator.
// Holds the CORDIC arctangent table and the coordinate saturation function.
// Depends on nothing; every other file of the block refers to it.
package evr_pkg;

    localparam int COORD_W     = 24;
    localparam int TRIG_W      = 18;
    localparam int PROD_W      = TRIG_W + COORD_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int MAT_SHIFT   = 16;
    localparam int RND_W       = ACC_W - MAT_SHIFT;
    localparam int ANGLE_RAW_W = 16;
    localparam int ANGLE_SHIFT = 17;
    localparam int ANGLE_W     = 34;
    localparam int CORDIC_W    = 32;
    localparam int TRIG_SHIFT  = 14;
    localparam int ATAN_DEPTH  = 24;
    localparam int ATAN_IDX_W  = $clog2(ATAN_DEPTH);
    localparam int ATAN_W      = 31;
    localparam int SAT_W       = 34;
    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int HALF_W      = 10;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_SIZE = 2'd2;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_ROTATE = 1'b1;

    localparam int RESET_HALF = 100;
    localparam int SCREEN_W   = 800;
    localparam int SCREEN_H   = 600;

    localparam logic signed [ANGLE_RAW_W-1:0] ANGLE_LIMIT = 16'sd25736;
    localparam logic signed [ANGLE_W-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [ANGLE_W-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sd652032874;

    localparam logic signed [SAT_W-1:0] SAT_MAX = 34'sd8388607;
    localparam logic signed [SAT_W-1:0] SAT_MIN = -34'sd8388608;

    typedef struct packed {
        logic                     done;
        logic signed [TRIG_W-1:0] cos_q;
        logic signed [TRIG_W-1:0] sin_q;
    } cordic_res_t;

    typedef struct packed {
        logic en;
        logic first;
        logic last;
    } mac_ctrl_t;

    typedef struct packed {
        logic                    valid;
        logic signed [RND_W-1:0] value;
    } mac_res_t;

    function automatic logic [ATAN_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 31'd843314856;
            5'd1:    v = 31'd497837829;
            5'd2:    v = 31'd263043836;
            5'd3:    v = 31'd133525158;
            5'd4:    v = 31'd67021686;
            5'd5:    v = 31'd33543515;
            5'd6:    v = 31'd16775850;
            5'd7:    v = 31'd8388437;
            5'd8:    v = 31'd4194282;
            5'd9:    v = 31'd2097149;
            5'd10:   v = 31'd1048575;
            5'd11:   v = 31'd524287;
            5'd12:   v = 31'd262143;
            5'd13:   v = 31'd131071;
            5'd14:   v = 31'd65535;
            5'd15:   v = 31'd32767;
            5'd16:   v = 31'd16383;
            5'd17:   v = 31'd8191;
            5'd18:   v = 31'd4095;
            5'd19:   v = 31'd2047;
            5'd20:   v = 31'd1023;
            5'd21:   v = 31'd511;
            5'd22:   v = 31'd255;
            5'd23:   v = 31'd127;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] s;
        if (v > SAT_MAX) begin
            s = SAT_MAX;
        end else if (v < SAT_MIN) begin
            s = SAT_MIN;
        end else begin
            s = v;
        end
        return s[COORD_W-1:0];
    endfunction

endpackage

// File: sv/euler_vertex_rotator_unit.sv
// Top level of the Euler vertex rotator: sequencer, corner store and output register.
// Instantiates evr_cordic and evr_mac; depends on evr_pkg.
//
// The block holds the eight corners of a cube, centred on the origin, with
// COORD_FRAC_BITS fraction bits. A load command (tuser 0) resets the corners
// to plus or minus cube_half_size; a rotate command (tuser 1) builds
// Rz(roll)*Rx(pitch) and rotates every stored corner in place, so rotations
// accumulate. Either command then sends eight transfers, corners 0 to 7, with
// the screen centre added to x and y and tlast on corner 7. Only one command is
// in work at a time; s_axis_tready is high while the block is idle. A rotate
// makes two CORDIC runs of one micro-rotation per cycle, then 76 products on the
// single shared multiplier, then the eight output transfers; a load sends only
// the eight output transfers.
// Output backpressure only lengthens the last phase.
module euler_vertex_rotator_unit #(
    parameter int COORD_FRAC_BITS   = 12,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // pitch [15:0], roll [31:16]
    input  logic [0:0]  s_axis_tuser,   // command [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // vertex_index [2:0], pos_x [26:3], pos_y [50:27],
                                        // pos_z [74:51], zero [79:75]
    output logic        m_axis_tlast,   // last
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    localparam int CO = evr_pkg::COORD_W;
    localparam int TW = evr_pkg::TRIG_W;
    localparam int SW = evr_pkg::SAT_W;
    localparam int RW = evr_pkg::ANGLE_RAW_W;
    localparam int CW = evr_pkg::CFG_W;
    localparam int HW = evr_pkg::HALF_W;
    localparam int PAD_W = 80 - 3 - 3 * CO;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_CORD_P    = 3'd1;
    localparam logic [2:0] ST_CORD_R    = 3'd2;
    localparam logic [2:0] ST_PROD      = 3'd3;
    localparam logic [2:0] ST_PROD_WAIT = 3'd4;
    localparam logic [2:0] ST_VERT      = 3'd5;
    localparam logic [2:0] ST_VDRAIN    = 3'd6;
    localparam logic [2:0] ST_OUT       = 3'd7;

    localparam logic [2:0] LAST_VERTEX = 3'd7;
    localparam logic [1:0] LAST_AXIS   = 2'd2;
    localparam logic [1:0] LAST_PROD   = 2'd3;

    localparam logic [CW-1:0] RESET_CENTER_X = CW'(evr_pkg::SCREEN_W / 2);
    localparam logic [CW-1:0] RESET_CENTER_Y = CW'(evr_pkg::SCREEN_H / 2);
    localparam logic [HW-1:0] RESET_HALF     = HW'(evr_pkg::RESET_HALF);
    localparam logic signed [SW-1:0] RESET_FIX = SW'(evr_pkg::RESET_HALF) << COORD_FRAC_BITS;
    localparam logic signed [CO-1:0] RESET_MAG = evr_pkg::sat_coord(RESET_FIX);

    function automatic logic corner_neg(input logic [2:0] k, input logic [1:0] axis);
        logic n;
        case (axis)
            2'd0:    n = ~(k[0] ^ k[1]);
            2'd1:    n = k[1];
            default: n = k[2];
        endcase
        return n;
    endfunction

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic [CW-1:0]          center_x_reg;
    logic [CW-1:0]          center_y_reg;
    logic [HW-1:0]          half_reg;
    logic signed [RW-1:0]   pitch_reg;
    logic signed [RW-1:0]   roll_reg;
    logic                   start_reg;
    logic signed [TW-1:0]   ca_reg;
    logic signed [TW-1:0]   sa_reg;
    logic signed [TW-1:0]   cg_reg;
    logic signed [TW-1:0]   sg_reg;
    logic signed [TW-1:0]   m01_reg;
    logic signed [TW-1:0]   m02_reg;
    logic signed [TW-1:0]   m11_reg;
    logic signed [TW-1:0]   m12_reg;
    logic [1:0]             pc_reg;
    logic [2:0]             vk_reg;
    logic [1:0]             vr_reg;
    logic [1:0]             vc_reg;
    logic [2:0]             ck_reg;
    logic [1:0]             cr_reg;
    logic [2:0]             ok_reg;
    logic signed [CO-1:0]   nv0_reg;
    logic signed [CO-1:0]   nv1_reg;
    logic signed [CO-1:0]   vtx_reg [8][3];
    logic                   out_valid_reg;
    logic [2:0]             out_idx_reg;
    logic signed [CO-1:0]   out_x_reg;
    logic signed [CO-1:0]   out_y_reg;
    logic signed [CO-1:0]   out_z_reg;
    logic                   out_last_reg;

    logic                   in_xfer;
    logic                   load_en;
    logic                   out_load;
    logic                   prod_phase;
    logic                   vert_phase;
    logic                   prod_cap;
    logic                   vert_cap;
    logic                   vert_write;
    logic [2:0]             rd_k;
    logic signed [CO-1:0]   row_sel [3];
    logic signed [CO-1:0]   operand_sel;
    logic signed [TW-1:0]   coef_sel;
    logic signed [RW-1:0]   cordic_angle;
    logic [SW-1:0]          half_fix;
    logic signed [CO-1:0]   load_mag;
    logic signed [SW-1:0]   cx_fix;
    logic signed [SW-1:0]   cy_fix;
    logic signed [CO-1:0]   cap_coord;
    logic signed [TW-1:0]   cap_trig;

    evr_pkg::cordic_res_t   cord_res;
    evr_pkg::mac_ctrl_t     mac_ctrl;
    logic signed [TW-1:0]   mac_coef;
    logic signed [CO-1:0]   mac_operand;
    evr_pkg::mac_res_t      mac_res;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign load_en       = in_xfer && (s_axis_tuser[0] == evr_pkg::CMD_LOAD);
    assign out_load      = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);
    assign prod_phase    = (state_reg == ST_PROD) || (state_reg == ST_PROD_WAIT);
    assign vert_phase    = (state_reg == ST_VERT) || (state_reg == ST_VDRAIN);
    assign prod_cap      = mac_res.valid && prod_phase;
    assign vert_cap      = mac_res.valid && vert_phase;
    assign vert_write    = vert_cap && (cr_reg == LAST_AXIS);

    assign cordic_angle = (state_reg == ST_CORD_R) ? roll_reg : pitch_reg;
    assign half_fix     = SW'(half_reg) << COORD_FRAC_BITS;
    assign load_mag     = evr_pkg::sat_coord(signed'(half_fix));
    assign cx_fix       = signed'(SW'(center_x_reg) << COORD_FRAC_BITS);
    assign cy_fix       = signed'(SW'(center_y_reg) << COORD_FRAC_BITS);
    assign cap_coord    = evr_pkg::sat_coord(SW'(mac_res.value));
    assign cap_trig     = mac_res.value[TW-1:0];

    assign rd_k = (state_reg == ST_OUT) ? ok_reg : vk_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++) begin
            row_sel[c] = vtx_reg[rd_k][c];
        end
        case (vc_reg)
            2'd0:    operand_sel = row_sel[0];
            2'd1:    operand_sel = row_sel[1];
            default: operand_sel = row_sel[2];
        endcase
        case ({vr_reg, vc_reg})
            4'b0000: coef_sel = cg_reg;
            4'b0001: coef_sel = m01_reg;
            4'b0010: coef_sel = m02_reg;
            4'b0100: coef_sel = sg_reg;
            4'b0101: coef_sel = m11_reg;
            4'b0110: coef_sel = m12_reg;
            4'b1001: coef_sel = sa_reg;
            4'b1010: coef_sel = ca_reg;
            default: coef_sel = '0;
        endcase
    end

    always_comb
    begin
        mac_ctrl    = '0;
        mac_coef    = '0;
        mac_operand = '0;
        if (state_reg == ST_PROD) begin
            mac_ctrl.en    = 1'b1;
            mac_ctrl.first = 1'b1;
            mac_ctrl.last  = 1'b1;
            case (pc_reg)
                2'd0:    begin mac_coef = sg_reg; mac_operand = CO'(ca_reg); end
                2'd1:    begin mac_coef = sg_reg; mac_operand = CO'(sa_reg); end
                2'd2:    begin mac_coef = cg_reg; mac_operand = CO'(ca_reg); end
                default: begin mac_coef = cg_reg; mac_operand = CO'(sa_reg); end
            endcase
        end else if (state_reg == ST_VERT) begin
            mac_ctrl.en    = 1'b1;
            mac_ctrl.first = (vc_reg == 2'd0);
            mac_ctrl.last  = (vc_reg == LAST_AXIS);
            mac_coef       = coef_sel;
            mac_operand    = operand_sel;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer) begin
                    state_next = load_en ? ST_OUT : ST_CORD_P;
                end
            end
            ST_CORD_P:
            begin
                if (cord_res.done) begin
                    state_next = ST_CORD_R;
                end
            end
            ST_CORD_R:
            begin
                if (cord_res.done) begin
                    state_next = ST_PROD;
                end
            end
            ST_PROD:
            begin
                if (pc_reg == LAST_PROD) begin
                    state_next = ST_PROD_WAIT;
                end
            end
            ST_PROD_WAIT:
            begin
                if (prod_cap && (cr_reg == LAST_PROD)) begin
                    state_next = ST_VERT;
                end
            end
            ST_VERT:
            begin
                if ((vk_reg == LAST_VERTEX) && (vr_reg == LAST_AXIS) && (vc_reg == LAST_AXIS)) begin
                    state_next = ST_VDRAIN;
                end
            end
            ST_VDRAIN:
            begin
                if (vert_write && (ck_reg == LAST_VERTEX)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load && (ok_reg == LAST_VERTEX)) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            center_x_reg  <= RESET_CENTER_X;
            center_y_reg  <= RESET_CENTER_Y;
            half_reg      <= RESET_HALF;
            start_reg     <= 1'b0;
            pc_reg        <= '0;
            vk_reg        <= '0;
            vr_reg        <= '0;
            vc_reg        <= '0;
            ck_reg        <= '0;
            cr_reg        <= '0;
            ok_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= (in_xfer && !load_en) || ((state_reg == ST_CORD_P) && cord_res.done);

            if (cfg_we) begin
                unique case (cfg_index)
                    evr_pkg::REG_CENTER_X:  center_x_reg <= cfg_data;
                    evr_pkg::REG_CENTER_Y:  center_y_reg <= cfg_data;
                    evr_pkg::REG_HALF_SIZE: half_reg     <= cfg_data[HW-1:0];
                    default:                ;
                endcase
            end

            if (state_reg == ST_PROD) begin
                pc_reg <= pc_reg + 1'b1;
            end

            if (state_reg == ST_VERT) begin
                if (vc_reg == LAST_AXIS) begin
                    vc_reg <= '0;
                    if (vr_reg == LAST_AXIS) begin
                        vr_reg <= '0;
                        vk_reg <= vk_reg + 1'b1;
                    end else begin
                        vr_reg <= vr_reg + 1'b1;
                    end
                end else begin
                    vc_reg <= vc_reg + 1'b1;
                end
            end

            if (prod_cap) begin
                cr_reg <= cr_reg + 1'b1;
            end else if (vert_cap) begin
                if (vert_write) begin
                    cr_reg <= '0;
                    ck_reg <= ck_reg + 1'b1;
                end else begin
                    cr_reg <= cr_reg + 1'b1;
                end
            end

            if (out_load) begin
                ok_reg        <= ok_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k < 8; k++) begin
                for (int c = 0; c < 3; c++) begin
                    vtx_reg[k][c] <= corner_neg(3'(k), 2'(c)) ? -RESET_MAG : RESET_MAG;
                end
            end
        end else if (load_en) begin
            for (int k = 0; k < 8; k++) begin
                for (int c = 0; c < 3; c++) begin
                    vtx_reg[k][c] <= corner_neg(3'(k), 2'(c)) ? -load_mag : load_mag;
                end
            end
        end else if (vert_write) begin
            vtx_reg[ck_reg][0] <= nv0_reg;
            vtx_reg[ck_reg][1] <= nv1_reg;
            vtx_reg[ck_reg][2] <= cap_coord;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer) begin
            pitch_reg <= signed'(s_axis_tdata[RW-1:0]);
            roll_reg  <= signed'(s_axis_tdata[2*RW-1:RW]);
        end
        if (cord_res.done && (state_reg == ST_CORD_P)) begin
            ca_reg <= cord_res.cos_q;
            sa_reg <= cord_res.sin_q;
        end
        if (cord_res.done && (state_reg == ST_CORD_R)) begin
            cg_reg <= cord_res.cos_q;
            sg_reg <= cord_res.sin_q;
        end
        if (prod_cap) begin
            case (cr_reg)
                2'd0:    m01_reg <= -cap_trig;
                2'd1:    m02_reg <= cap_trig;
                2'd2:    m11_reg <= cap_trig;
                default: m12_reg <= -cap_trig;
            endcase
        end
        if (vert_cap && (cr_reg == 2'd0)) begin
            nv0_reg <= cap_coord;
        end
        if (vert_cap && (cr_reg == 2'd1)) begin
            nv1_reg <= cap_coord;
        end
        if (out_load) begin
            out_idx_reg  <= ok_reg;
            out_x_reg    <= evr_pkg::sat_coord(SW'(row_sel[0]) + cx_fix);
            out_y_reg    <= evr_pkg::sat_coord(SW'(row_sel[1]) + cy_fix);
            out_z_reg    <= row_sel[2];
            out_last_reg <= (ok_reg == LAST_VERTEX);
        end
    end

    evr_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .angle (cordic_angle),
        .res   (cord_res)
    );

    evr_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .coef    (mac_coef),
        .operand (mac_operand),
        .res     (mac_res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_z_reg, out_y_reg, out_x_reg, out_idx_reg};

`ifndef ASSERT_OFF
    a_last_is_corner7: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[2:0] == LAST_VERTEX))
        else $error("tlast on a corner other than the last");

    a_cordic_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        cord_res.done |-> ((state_reg == ST_CORD_P) || (state_reg == ST_CORD_R)))
        else $error("CORDIC result outside an angle phase");

    a_mac_result_state: assert property (@(posedge clk) disable iff (!rst_n)
        mac_res.valid |-> ((state_reg == ST_PROD) || (state_reg == ST_PROD_WAIT)
                           || (state_reg == ST_VERT) || (state_reg == ST_VDRAIN)))
        else $error("multiplier result with no phase to take it");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second command accepted while one is in work");
`endif

endmodule

// File: sv/evr_cordic.sv
// Iterative CORDIC in rotation mode: one micro-rotation per clock.
// Clamps and folds a Q2.13 angle, returns cosine and sine rounded to Q16.
// Depends on evr_pkg for widths, constants and the arctangent table.
module evr_cordic #(
    parameter int ITERATIONS = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  logic signed [evr_pkg::ANGLE_RAW_W-1:0]      angle,
    output evr_pkg::cordic_res_t                        res
);

    localparam int IDX_W = evr_pkg::ATAN_IDX_W;
    localparam int AW    = evr_pkg::ANGLE_W;
    localparam int CW    = evr_pkg::CORDIC_W;
    localparam int XW    = CW + 1;
    localparam int TW    = evr_pkg::TRIG_W;
    localparam int RW    = evr_pkg::ANGLE_RAW_W;
    localparam int PAD_W = AW - RW - evr_pkg::ANGLE_SHIFT;
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(ITERATIONS - 1);
    localparam logic signed [XW-1:0] TRIG_HALF = XW'(1) << (evr_pkg::TRIG_SHIFT - 1);

    logic                   busy_reg;
    logic                   fin_reg;
    logic                   done_reg;
    logic [IDX_W-1:0]       step_reg;
    logic signed [CW-1:0]   x_reg;
    logic signed [CW-1:0]   y_reg;
    logic signed [AW-1:0]   z_reg;
    logic                   flip_reg;
    logic signed [TW-1:0]   cos_reg;
    logic signed [TW-1:0]   sin_reg;

    logic signed [RW-1:0]   a_clamped;
    logic signed [AW-1:0]   z_in;
    logic signed [AW-1:0]   z_fold;
    logic                   flip_in;
    logic signed [CW-1:0]   dx;
    logic signed [CW-1:0]   dy;
    logic signed [AW-1:0]   atan_step;
    logic signed [XW-1:0]   x_final;
    logic signed [XW-1:0]   y_final;
    logic signed [XW-1:0]   x_round;
    logic signed [XW-1:0]   y_round;

    always_comb
    begin
        if (angle > evr_pkg::ANGLE_LIMIT) begin
            a_clamped = evr_pkg::ANGLE_LIMIT;
        end else if (angle < -evr_pkg::ANGLE_LIMIT) begin
            a_clamped = -evr_pkg::ANGLE_LIMIT;
        end else begin
            a_clamped = angle;
        end
        z_in = {{PAD_W{a_clamped[RW-1]}}, a_clamped, {evr_pkg::ANGLE_SHIFT{1'b0}}};
        // Angles beyond a quarter turn are folded by pi and the result negated.
        if (z_in > evr_pkg::Q30_HALF_PI) begin
            z_fold  = z_in - evr_pkg::Q30_PI;
            flip_in = 1'b1;
        end else if (z_in < -evr_pkg::Q30_HALF_PI) begin
            z_fold  = z_in + evr_pkg::Q30_PI;
            flip_in = 1'b1;
        end else begin
            z_fold  = z_in;
            flip_in = 1'b0;
        end
    end

    assign dx        = y_reg >>> step_reg;
    assign dy        = x_reg >>> step_reg;
    assign atan_step = signed'(AW'(evr_pkg::atan_q30(step_reg)));

    assign x_final = flip_reg ? -XW'(x_reg) : XW'(x_reg);
    assign y_final = flip_reg ? -XW'(y_reg) : XW'(y_reg);
    assign x_round = (x_final + TRIG_HALF) >>> evr_pkg::TRIG_SHIFT;
    assign y_round = (y_final + TRIG_HALF) >>> evr_pkg::TRIG_SHIFT;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                    step_reg <= '0;
                end else begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            x_reg    <= evr_pkg::CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= z_fold;
            flip_reg <= flip_in;
        end else if (busy_reg) begin
            if (z_reg[AW-1]) begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_step;
            end else begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_step;
            end
        end
        if (fin_reg) begin
            cos_reg <= x_round[TW-1:0];
            sin_reg <= y_round[TW-1:0];
        end
    end

    assign res.done  = done_reg;
    assign res.cos_q = cos_reg;
    assign res.sin_q = sin_reg;

endmodule

// File: sv/evr_mac.sv
// Shared multiply-accumulate unit: a registered multiplier feeding an accumulator.
// Reports each finished sum rounded by 16 fraction bits from the accumulator.
// Depends on evr_pkg for widths and the control and result structs.
module evr_mac (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  evr_pkg::mac_ctrl_t                      ctrl,
    input  logic signed [evr_pkg::TRIG_W-1:0]       coef,
    input  logic signed [evr_pkg::COORD_W-1:0]      operand,
    output evr_pkg::mac_res_t                       res
);

    localparam int PW = evr_pkg::PROD_W;
    localparam int AW = evr_pkg::ACC_W;
    localparam int RW = evr_pkg::RND_W;
    localparam logic signed [AW-1:0] ACC_HALF = AW'(1) << (evr_pkg::MAT_SHIFT - 1);

    evr_pkg::mac_ctrl_t     stage_reg;
    logic                   valid_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [AW-1:0]   acc_reg;
    logic signed [AW-1:0]   acc_round;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            stage_reg <= ctrl;
            valid_reg <= stage_reg.en & stage_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en) begin
            prod_reg <= coef * operand;
        end
        if (stage_reg.en) begin
            acc_reg <= (stage_reg.first ? '0 : acc_reg) + AW'(prod_reg);
        end
    end

    assign acc_round = (acc_reg + ACC_HALF) >>> evr_pkg::MAT_SHIFT;
    assign res.valid = valid_reg;
    assign res.value = acc_round[RW-1:0];

endmodule
